// ===== hdl/lsbo_pkg.sv =====
// Package for the line-of-sight box occlusion unit.
// Word types, widths, register codes and the state type of the back end.
// No dependencies.
package lsbo_pkg;

  localparam int unsigned CoordW   = 20;
  localparam int unsigned MaxWalls = 16;
  localparam int unsigned SlotW    = $clog2(MaxWalls);
  localparam int unsigned CountW   = 5;
  localparam int unsigned StepW    = 12;
  localparam int unsigned DeltaW   = CoordW + 1;
  localparam int unsigned SqW      = 2 * DeltaW;
  localparam int unsigned RootW    = DeltaW;
  localparam int unsigned UnitSh   = 16;
  localparam int unsigned UnitW    = UnitSh + 1;
  localparam int unsigned NumW     = DeltaW + UnitSh;
  localparam int unsigned LenW     = RootW + 1;
  localparam int unsigned PosW     = CoordW + 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = StepW;

  localparam logic [CfgIdxW-1:0] CFG_WALL_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_LEN   = 2'd1;
  localparam logic [StepW-1:0]   STEP_LEN_RST   = 12'd160;

  typedef struct packed {
    logic                     req_type;
    logic [3:0]               wall_index;
    logic signed [CoordW-1:0] box_x_min;
    logic signed [CoordW-1:0] box_y_min;
    logic signed [CoordW-1:0] box_x_max;
    logic signed [CoordW-1:0] box_y_max;
    logic signed [CoordW-1:0] from_x;
    logic signed [CoordW-1:0] from_y;
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
  } in_t;

  typedef struct packed {
    logic                     visible;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
  } out_t;

  typedef enum logic {OP_LOAD, OP_QUERY} op_e;

  typedef struct packed {
    op_e op;
    in_t w;
  } entry_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x_min;
    logic signed [CoordW-1:0] y_min;
    logic signed [CoordW-1:0] x_max;
    logic signed [CoordW-1:0] y_max;
  } box_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [RootW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_DSTEP, ST_WSTEP, ST_DUX, ST_WUX,
    ST_DUY, ST_WUY, ST_MUL, ST_CHK, ST_OUT
  } state_e;

endpackage

// ===== hdl/lsbo_front.sv =====
// Front end: takes input words and classifies them into queue entries.
// Depends on lsbo_pkg.
module lsbo_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lsbo_pkg::in_t     in_word_i,
  output logic              push_o,
  output lsbo_pkg::entry_t  entry_o,
  input  logic              full_i
);
  import lsbo_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q;
  logic   take;

  assign push_o     = valid_q;
  assign entry_o    = entry_q;
  assign in_stall_o = valid_q & full_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !full_i) valid_d = 1'b0;
    if (take) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q.op <= in_word_i.req_type ? OP_QUERY : OP_LOAD;
      entry_q.w  <= in_word_i;
    end
  end

endmodule

// ===== hdl/lsbo_fifo.sv =====
// Two-entry queue between front and back end.
// Depends on lsbo_pkg.
module lsbo_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsbo_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lsbo_pkg::entry_t data_o
);
  import lsbo_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

// ===== hdl/lsbo_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on lsbo_pkg.
module lsbo_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsbo_pkg::div_req_t req_i,
  output lsbo_pkg::div_rsp_t rsp_o
);
  import lsbo_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q;
  logic [RootW-1:0] den_q;
  logic [RootW:0]   rem_q, rem_sh;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic             ge;

  assign rem_sh = {rem_q[RootW-1:0], num_q[NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rsp_o  = '{done: done_q, quot: num_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      num_q <= {num_q[NumW-2:0], ge};
    end
  end

endmodule

// ===== hdl/lsbo_back.sv =====
// Back end: wall table, distance root, unit vector and the sample march.
// Depends on lsbo_pkg and lsbo_div.
module lsbo_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  lsbo_pkg::entry_t            entry_i,
  output logic                        pop_o,
  input  logic [lsbo_pkg::CountW-1:0] wall_count_i,
  input  logic [lsbo_pkg::StepW-1:0]  step_len_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lsbo_pkg::out_t              out_word_o
);
  import lsbo_pkg::*;

  state_e state_q, state_d;
  box_t   table_q [MaxWalls];

  logic signed [CoordW-1:0] fx_q, fy_q;
  logic [DeltaW-1:0]        adx_q, ady_q;
  logic                     sx_q, sy_q;
  logic [CountW-1:0]        count_q;
  logic [SqW-1:0]           sq_q, n_q;
  logic [RootW+2:0]         rem_q;
  logic [RootW-1:0]         root_q;
  logic [4:0]               rcnt_q;
  logic [RootW-1:0]         steps_q, k_q;
  logic [UnitW-1:0]         ux_q, uy_q;
  logic [LenW-1:0]          len_q;
  logic [PosW-1:0]          px_q, py_q;
  logic                     out_valid_q;
  out_t                     out_q;
  out_t                     res_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     out_free, hit;
  logic [RootW+2:0]         rem_sh, trial;
  logic signed [PosW-1:0]   cx, cy;
  logic [MaxWalls-1:0]      in_box;
  logic [UnitW+LenW-1:0]    mx, my;
  logic signed [DeltaW-1:0] dx, dy;

  lsbo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign dx = DeltaW'(entry_i.w.target_x) - DeltaW'(entry_i.w.from_x);
  assign dy = DeltaW'(entry_i.w.target_y) - DeltaW'(entry_i.w.from_y);

  assign rem_sh = {rem_q[RootW:0], n_q[SqW-1:SqW-2]};
  assign trial  = {root_q, 2'b01};

  assign mx = ux_q * len_q;
  assign my = uy_q * len_q;
  assign cx = PosW'(fx_q) + (sx_q ? -$signed(px_q) : $signed(px_q));
  assign cy = PosW'(fy_q) + (sy_q ? -$signed(py_q) : $signed(py_q));

  always_comb begin
    for (int j = 0; j < MaxWalls; j++) begin
      in_box[j] = (count_q > CountW'(j))
        && cx > PosW'(table_q[j].x_min) && cx < PosW'(table_q[j].x_max)
        && cy > PosW'(table_q[j].y_min) && cy < PosW'(table_q[j].y_max);
    end
  end
  assign hit = |in_box;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (!empty_i && entry_i.op == OP_QUERY) state_d = ST_SQX;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_ROOT;
      ST_ROOT:  if (rcnt_q == 5'd0) state_d = ST_DSTEP;
      ST_DSTEP: state_d = (step_len_i == '0 || root_q == '0) ? ST_OUT : ST_WSTEP;
      ST_WSTEP: if (div_rsp.done) begin
        state_d = (div_rsp.quot[RootW-1:0] == '0) ? ST_OUT : ST_DUX;
      end
      ST_DUX:   state_d = ST_WUX;
      ST_WUX:   if (div_rsp.done) state_d = ST_DUY;
      ST_DUY:   state_d = ST_WUY;
      ST_WUY:   if (div_rsp.done) state_d = ST_MUL;
      ST_MUL:   state_d = ST_CHK;
      ST_CHK:   state_d = (hit || k_q + 1'b1 == steps_q) ? ST_OUT : ST_MUL;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o   = 1'b0;
    div_req = '{start: 1'b0, num: '0, den: root_q};
    case (state_q)
      ST_IDLE:  pop_o = ~empty_i;
      ST_DSTEP: begin
        div_req.start = (step_len_i != '0) && (root_q != '0);
        div_req.num   = NumW'(root_q);
        div_req.den   = RootW'(step_len_i);
      end
      ST_DUX:   begin
        div_req.start = 1'b1;
        div_req.num   = {adx_q, {UnitSh{1'b0}}};
      end
      ST_DUY:   begin
        div_req.start = 1'b1;
        div_req.num   = {ady_q, {UnitSh{1'b0}}};
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (!empty_i) begin
        if (entry_i.op == OP_LOAD) begin
          table_q[entry_i.w.wall_index[SlotW-1:0]] <= '{
            x_min: entry_i.w.box_x_min, y_min: entry_i.w.box_y_min,
            x_max: entry_i.w.box_x_max, y_max: entry_i.w.box_y_max};
        end else begin
          fx_q    <= entry_i.w.from_x;
          fy_q    <= entry_i.w.from_y;
          sx_q    <= dx[DeltaW-1];
          sy_q    <= dy[DeltaW-1];
          adx_q   <= dx[DeltaW-1] ? -dx : dx;
          ady_q   <= dy[DeltaW-1] ? -dy : dy;
          count_q <= (wall_count_i > CountW'(MaxWalls)) ? CountW'(MaxWalls) : wall_count_i;
          res_q   <= '{visible: 1'b1, hit_x: entry_i.w.from_x, hit_y: entry_i.w.from_y};
        end
      end
      ST_SQX:  sq_q <= adx_q * adx_q;
      ST_SQY:  begin
        n_q    <= sq_q + ady_q * ady_q;
        rem_q  <= '0;
        root_q <= '0;
        rcnt_q <= 5'(RootW);
      end
      ST_ROOT: if (rcnt_q != 5'd0) begin
        n_q    <= {n_q[SqW-3:0], 2'b00};
        rcnt_q <= rcnt_q - 1'b1;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      ST_WSTEP: steps_q <= div_rsp.quot[RootW-1:0];
      ST_WUX:  ux_q <= div_rsp.quot[UnitW-1:0];
      ST_WUY:  begin
        uy_q  <= div_rsp.quot[UnitW-1:0];
        k_q   <= '0;
        len_q <= '0;
      end
      ST_MUL:  begin
        px_q <= mx[UnitSh +: PosW];
        py_q <= my[UnitSh +: PosW];
      end
      ST_CHK:  begin
        k_q   <= k_q + 1'b1;
        len_q <= len_q + LenW'(step_len_i);
        if (hit) res_q <= '{visible: 1'b0, hit_x: cx[CoordW-1:0], hit_y: cy[CoordW-1:0]};
      end
      ST_OUT:  if (out_free) out_q <= res_q;
      default: ;
    endcase
  end

endmodule

// ===== hdl/line_of_sight_box_occlusion_unit.sv =====
// Top level of the line-of-sight box occlusion unit: config registers,
// front end, queue and back end. Depends on lsbo_pkg and all lsbo_* modules.
//
//   port group   dir  word / handshake
//   in           in   in_word_i, in_valid_i, in_stall_o
//   out          out  out_word_o, out_valid_o, out_stall_i
//   cfg          in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// A load writes the wall table. A query computes squares and root, runs up
// to three divisions on the shared serial divider, then marches samples.
// Reset clears config (wall_count 0, step_len 160) and all handshake state;
// the wall table is undefined until loaded. The front register and two-entry
// queue keep accepting words until full while a result waits on out_stall_i.
module line_of_sight_box_occlusion_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lsbo_pkg::in_t                 in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lsbo_pkg::out_t                out_word_o,
  input  logic                          cfg_we_i,
  input  logic [lsbo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsbo_pkg::CfgDataW-1:0] cfg_data_i
);
  import lsbo_pkg::*;

  logic [CountW-1:0] wall_count_q;
  logic [StepW-1:0]  step_len_q;
  logic              push, full, pop, empty;
  entry_t            f_entry, b_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_count_q <= '0;
      step_len_q   <= STEP_LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WALL_COUNT) wall_count_q <= cfg_data_i[CountW-1:0];
      if (cfg_idx_i == CFG_STEP_LEN) step_len_q <= cfg_data_i[StepW-1:0];
    end
  end

  lsbo_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .push_o     (push),
    .entry_o    (f_entry),
    .full_i     (full)
  );

  lsbo_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (b_entry)
  );

  lsbo_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (b_entry),
    .pop_o        (pop),
    .wall_count_i (wall_count_q),
    .step_len_i   (step_len_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule
